### src/quaternion_arithmetic_unit_assert.svh
// assertion macros shared by the checker
`ifndef QUATERNION_ARITHMETIC_UNIT_ASSERT_SVH
`define QUATERNION_ARITHMETIC_UNIT_ASSERT_SVH

// same-cycle implication
`define QAU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("qau check failed");

// next-cycle implication
`define QAU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("qau check failed");

`endif

### src/qau_pkg.sv
package qau_pkg;

  typedef logic signed [15:0] q_t;
  typedef logic signed [31:0] wide_t;
  typedef logic signed [21:0] nv_t;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_MULT  = 4'd2,
    OP_CONJ  = 4'd3,
    OP_SCALE = 4'd4,
    OP_DOT   = 4'd5,
    OP_NORM  = 4'd6,
    OP_INV   = 4'd7,
    OP_ROT   = 4'd8,
    OP_MIX   = 4'd9,
    OP_NLERP = 4'd10,
    OP_NONE  = 4'd15
  } op_e;

  localparam int unsigned FracBits  = 12;
  localparam int unsigned RotShift  = 24;
  localparam int unsigned QueDepth  = 2;
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned DivSteps  = 16;

  typedef struct packed {
    logic [3:0] mode;
    q_t         a_i;
    q_t         a_j;
    q_t         a_k;
    q_t         a_w;
    q_t         b_i;
    q_t         b_j;
    q_t         b_k;
    q_t         b_w;
    q_t         factor;
  } qau_in_t;

  typedef struct packed {
    q_t   r_i;
    q_t   r_j;
    q_t   r_k;
    q_t   r_w;
    q_t   r_scalar;
    logic zero_flag;
    logic overflow;
  } qau_out_t;

  typedef struct packed {
    op_e        op;
    q_t [3:0]   a;
    q_t [3:0]   b;
    q_t         f;
  } fe_t;

  typedef struct packed {
    op_e         op;
    logic        zero;
    wide_t [3:0] res;
    wide_t       scal;
    nv_t [3:0]   n;
    logic [43:0] m2;
  } bk_t;

  typedef struct packed {
    bk_t         c;
    logic [31:0] s;
  } sq_t;

  typedef struct packed {
    q_t   val;
    logic ovf;
  } sat_t;

  // round to nearest, ties away from zero, then keep 32 bits
  function automatic wide_t rnd(input logic signed [63:0] v, input int unsigned k);
    logic [63:0] mag;
    logic [63:0] m;
    logic [63:0] r;
    mag = v[63] ? (64'd0 - v) : v;
    m   = (mag + (64'd1 << (k - 1))) >> k;
    r   = v[63] ? (64'd0 - m) : m;
    return r[31:0];
  endfunction

  function automatic sat_t sat16(input wide_t v);
    sat_t s;
    if (v > 32'sd32767) begin
      s.val = 16'sh7fff;
      s.ovf = 1'b1;
    end else if (v < -32'sd32768) begin
      s.val = 16'sh8000;
      s.ovf = 1'b1;
    end else begin
      s.val = v[15:0];
      s.ovf = 1'b0;
    end
    return s;
  endfunction

endpackage

### src/qau_front.sv
module qau_front import qau_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  qau_in_t in_word_i,
  input  logic    deq_i,
  output logic    fe_valid_o,
  output fe_t     fe_word_o
);

  fe_t        mem_q [QueDepth];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  fe_t        fe_d;
  logic       push, pop;

  always_comb begin
    fe_d = '0;
    if (in_word_i.mode <= 4'(OP_NLERP)) begin
      fe_d.op = op_e'(in_word_i.mode);
    end else begin
      fe_d.op = OP_NONE;
    end
    fe_d.a = {in_word_i.a_w, in_word_i.a_k, in_word_i.a_j, in_word_i.a_i};
    fe_d.b = {in_word_i.b_w, in_word_i.b_k, in_word_i.b_j, in_word_i.b_i};
    fe_d.f = in_word_i.factor;
  end

  assign in_stall_o = (cnt_q == 2'(QueDepth));
  assign push       = in_valid_i && !in_stall_o;
  assign fe_valid_o = (cnt_q != 2'd0);
  assign pop        = fe_valid_o && deq_i;
  assign fe_word_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= fe_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

### src/qau_arith.sv
module qau_arith import qau_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  fe_t  word_i,
  output logic valid_o,
  output bk_t  word_o
);

  // stage 1: products
  q_t                 a_in [4];
  q_t                 b_in [4];
  q_t                 f_in;
  logic signed [16:0] m_in [4];

  logic               v1_q;
  op_e                op1_q;
  q_t                 a1_q [4];
  q_t                 b1_q [4];
  logic signed [31:0] cr_q [4][4];
  logic signed [31:0] sq_q [4];
  logic signed [32:0] pf_q [4];

  always_comb begin
    f_in = word_i.f;
    for (int x = 0; x < 4; x++) begin
      a_in[x] = word_i.a[x];
      b_in[x] = word_i.b[x];
      m_in[x] = (word_i.op == OP_SCALE) ? 17'(a_in[x]) : (17'(b_in[x]) - 17'(a_in[x]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op1_q <= word_i.op;
      for (int x = 0; x < 4; x++) begin
        a1_q[x] <= a_in[x];
        b1_q[x] <= b_in[x];
        sq_q[x] <= a_in[x] * a_in[x];
        pf_q[x] <= m_in[x] * f_in;
        for (int y = 0; y < 4; y++) begin
          cr_q[x][y] <= a_in[x] * b_in[y];
        end
      end
    end
  end

  // stage 2: sums and rounding
  wide_t              res2_d [4];
  wide_t              scal2_d;
  nv_t                n2_d [4];
  wide_t              lin [4];
  logic signed [33:0] qv2_d, wq2_d;
  logic signed [32:0] c2_d [3];

  logic               v2_q;
  op_e                op2_q;
  wide_t              res2_q [4];
  wide_t              scal2_q;
  nv_t                n2_q [4];
  logic signed [33:0] qv2_q, wq2_q;
  logic signed [32:0] c2_q [3];
  q_t                 a2_q [4];
  q_t                 b2_q [4];

  always_comb begin
    for (int x = 0; x < 4; x++) begin
      lin[x]    = rnd((64'(a1_q[x]) <<< FracBits) + 64'(pf_q[x]), FracBits);
      res2_d[x] = '0;
      n2_d[x]   = '0;
    end
    scal2_d = '0;
    case (op1_q)
      OP_ADD: begin
        for (int x = 0; x < 4; x++) res2_d[x] = 32'(a1_q[x]) + 32'(b1_q[x]);
      end
      OP_SUB: begin
        for (int x = 0; x < 4; x++) res2_d[x] = 32'(a1_q[x]) - 32'(b1_q[x]);
      end
      OP_CONJ: begin
        for (int x = 0; x < 3; x++) res2_d[x] = -32'(a1_q[x]);
        res2_d[3] = 32'(a1_q[3]);
      end
      OP_MULT: begin
        res2_d[0] = rnd(64'(cr_q[3][0]) + 64'(cr_q[0][3]) + 64'(cr_q[1][2])
                        - 64'(cr_q[2][1]), FracBits);
        res2_d[1] = rnd(64'(cr_q[3][1]) - 64'(cr_q[0][2]) + 64'(cr_q[1][3])
                        + 64'(cr_q[2][0]), FracBits);
        res2_d[2] = rnd(64'(cr_q[3][2]) + 64'(cr_q[0][1]) - 64'(cr_q[1][0])
                        + 64'(cr_q[2][3]), FracBits);
        res2_d[3] = rnd(64'(cr_q[3][3]) - 64'(cr_q[0][0]) - 64'(cr_q[1][1])
                        - 64'(cr_q[2][2]), FracBits);
      end
      OP_SCALE: begin
        for (int x = 0; x < 4; x++) res2_d[x] = rnd(64'(pf_q[x]), FracBits);
      end
      OP_DOT: begin
        scal2_d = rnd(64'(cr_q[0][0]) + 64'(cr_q[1][1]) + 64'(cr_q[2][2])
                      + 64'(cr_q[3][3]), FracBits);
      end
      OP_MIX: begin
        for (int x = 0; x < 4; x++) res2_d[x] = lin[x];
      end
      default: begin
      end
    endcase
    case (op1_q) inside
      OP_NORM, OP_INV: begin
        for (int x = 0; x < 4; x++) n2_d[x] = 22'(a1_q[x]);
      end
      OP_NLERP: begin
        for (int x = 0; x < 4; x++) n2_d[x] = lin[x][21:0];
      end
      default: begin
      end
    endcase
    qv2_d   = 34'(cr_q[0][0]) + 34'(cr_q[1][1]) + 34'(cr_q[2][2]);
    wq2_d   = 34'(sq_q[3]) - 34'(sq_q[0]) - 34'(sq_q[1]) - 34'(sq_q[2]);
    c2_d[0] = 33'(cr_q[1][2]) - 33'(cr_q[2][1]);
    c2_d[1] = 33'(cr_q[2][0]) - 33'(cr_q[0][2]);
    c2_d[2] = 33'(cr_q[0][1]) - 33'(cr_q[1][0]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op2_q   <= op1_q;
      scal2_q <= scal2_d;
      qv2_q   <= qv2_d;
      wq2_q   <= wq2_d;
      for (int x = 0; x < 4; x++) begin
        res2_q[x] <= res2_d[x];
        n2_q[x]   <= n2_d[x];
        a2_q[x]   <= a1_q[x];
        b2_q[x]   <= b1_q[x];
      end
      for (int x = 0; x < 3; x++) c2_q[x] <= c2_d[x];
    end
  end

  // stage 3: squares of n and rotation products
  logic               v3_q;
  op_e                op3_q;
  wide_t              res3_q [4];
  wide_t              scal3_q;
  nv_t                n3_q [4];
  logic [43:0]        nsq_q [4];
  logic signed [49:0] t1_q [3];
  logic signed [49:0] t2_q [3];
  logic signed [48:0] t3_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op3_q   <= op2_q;
      scal3_q <= scal2_q;
      for (int x = 0; x < 4; x++) begin
        res3_q[x] <= res2_q[x];
        n3_q[x]   <= n2_q[x];
        nsq_q[x]  <= n2_q[x] * n2_q[x];
      end
      for (int x = 0; x < 3; x++) begin
        t1_q[x] <= qv2_q * a2_q[x];
        t2_q[x] <= wq2_q * b2_q[x];
        t3_q[x] <= c2_q[x] * a2_q[3];
      end
    end
  end

  // stage 4: magnitude sum and rotation result
  logic [45:0] m2_sum;
  bk_t         word_d;

  always_comb begin
    m2_sum      = 46'(nsq_q[0]) + 46'(nsq_q[1]) + 46'(nsq_q[2]) + 46'(nsq_q[3]);
    word_d      = '0;
    word_d.op   = op3_q;
    word_d.m2   = m2_sum[43:0];
    word_d.zero = (m2_sum == 46'd0);
    word_d.scal = scal3_q;
    for (int x = 0; x < 4; x++) begin
      word_d.res[x] = res3_q[x];
      word_d.n[x]   = n3_q[x];
    end
    if (op3_q == OP_ROT) begin
      for (int x = 0; x < 3; x++) begin
        word_d.res[x] = rnd((64'(t1_q[x]) <<< 1) + 64'(t2_q[x]) + (64'(t3_q[x]) <<< 1),
                            RotShift);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_o <= word_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      v1_q    <= valid_i;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      valid_o <= v3_q;
    end
  end

endmodule

### src/qau_sqrt.sv
module qau_sqrt import qau_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  bk_t  word_i,
  output logic valid_o,
  output sq_t  word_o
);

  logic        v_q [SqrtSteps+1];
  logic [63:0] x_q [SqrtSteps];
  logic [63:0] r_q [SqrtSteps+1];
  bk_t         c_q [SqrtSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= {word_i.m2, 20'd0};
      r_q[0] <= '0;
      c_q[0] <= word_i;
    end
  end

  for (genvar g = 0; g < SqrtSteps; g++) begin : g_step
    localparam logic [63:0] StepBit = 64'd1 << (62 - 2 * g);
    logic [63:0] trial;
    logic        take;

    assign trial = r_q[g] + StepBit;
    assign take  = (x_q[g] >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g+1] <= 1'b0;
      end else if (en_i) begin
        v_q[g+1] <= v_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[g+1] <= take ? ((r_q[g] >> 1) + StepBit) : (r_q[g] >> 1);
        c_q[g+1] <= c_q[g];
      end
    end

    if (g < SqrtSteps - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          x_q[g+1] <= take ? (x_q[g] - trial) : x_q[g];
        end
      end
    end
  end

  assign valid_o  = v_q[SqrtSteps];
  assign word_o.c = c_q[SqrtSteps];
  assign word_o.s = r_q[SqrtSteps][31:0];

endmodule

### src/qau_div.sv
module qau_div import qau_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  sq_t      word_i,
  output logic     valid_o,
  output qau_out_t word_o
);

  localparam int unsigned DW        = 49;
  localparam int unsigned NormShift = 22;
  localparam int unsigned InvShift  = 24;

  // setup
  logic [32:0]   den_d;
  logic [DW-1:0] num_d [4];
  logic [3:0]    neg_d, big_d;
  nv_t           nn;
  logic [21:0]   mag;
  logic          inv;

  always_comb begin
    inv   = (word_i.c.op == OP_INV);
    den_d = inv ? word_i.c.m2[32:0] : {1'b0, word_i.s};
    for (int x = 0; x < 4; x++) begin
      nn       = word_i.c.n[x];
      mag      = nn[21] ? (22'd0 - nn) : nn;
      num_d[x] = (inv ? (DW'(mag) << InvShift) : (DW'(mag) << NormShift))
                 + DW'(den_d >> 1);
      neg_d[x] = nn[21] ^ (inv && (x != 3));
      big_d[x] = (num_d[x] >= (DW'(den_d) << DivSteps));
    end
  end

  logic          v_q   [DivSteps+1];
  logic [32:0]   den_q [DivSteps+1];
  logic [DW-1:0] rem_q [DivSteps][4];
  logic [15:0]   quo_q [DivSteps+1][4];
  logic [3:0]    neg_q [DivSteps+1];
  logic [3:0]    big_q [DivSteps+1];
  bk_t           c_q   [DivSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q[0] <= den_d;
      neg_q[0] <= neg_d;
      big_q[0] <= big_d;
      c_q[0]   <= word_i.c;
      for (int x = 0; x < 4; x++) begin
        rem_q[0][x] <= num_d[x];
        quo_q[0][x] <= '0;
      end
    end
  end

  for (genvar g = 0; g < DivSteps; g++) begin : g_step
    localparam int unsigned Pos = DivSteps - 1 - g;
    logic [DW-1:0] sub;
    logic [3:0]    take;

    assign sub = DW'(den_q[g]) << Pos;
    for (genvar l = 0; l < 4; l++) begin : g_lane
      assign take[l] = (rem_q[g][l] >= sub);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g+1] <= 1'b0;
      end else if (en_i) begin
        v_q[g+1] <= v_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[g+1] <= den_q[g];
        neg_q[g+1] <= neg_q[g];
        big_q[g+1] <= big_q[g];
        c_q[g+1]   <= c_q[g];
        for (int x = 0; x < 4; x++) begin
          quo_q[g+1][x] <= quo_q[g][x] | (16'(take[x]) << Pos);
        end
      end
    end

    if (g < DivSteps - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          for (int x = 0; x < 4; x++) begin
            rem_q[g+1][x] <= take[x] ? (rem_q[g][x] - sub) : rem_q[g][x];
          end
        end
      end
    end
  end

  // result select and saturation
  bk_t      cf;
  sat_t     s [4];
  sat_t     ss;
  wide_t    mq;
  logic     normop;
  qau_out_t word_d;

  always_comb begin
    cf     = c_q[DivSteps];
    normop = (cf.op == OP_NORM) || (cf.op == OP_INV) || (cf.op == OP_NLERP);
    for (int x = 0; x < 4; x++) begin
      mq = 32'(quo_q[DivSteps][x]);
      if (neg_q[DivSteps][x]) begin
        mq = -mq;
      end
      if (!normop) begin
        s[x] = sat16(cf.res[x]);
      end else if (cf.zero) begin
        s[x] = '0;
      end else if (big_q[DivSteps][x]) begin
        s[x].val = neg_q[DivSteps][x] ? 16'sh8000 : 16'sh7fff;
        s[x].ovf = 1'b1;
      end else begin
        s[x] = sat16(mq);
      end
    end
    ss                 = sat16(cf.scal);
    word_d.r_i         = s[0].val;
    word_d.r_j         = s[1].val;
    word_d.r_k         = s[2].val;
    word_d.r_w         = s[3].val;
    word_d.r_scalar    = ss.val;
    word_d.zero_flag   = normop && cf.zero;
    word_d.overflow    = s[0].ovf | s[1].ovf | s[2].ovf | s[3].ovf | ss.ovf;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_o <= word_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= v_q[DivSteps];
    end
  end

endmodule

### src/quaternion_arithmetic_unit.sv
// channel  direction  handshake                 word
// in       input      in_valid_i / in_stall_o   qau_in_t
// out      output     out_valid_o / out_stall_i qau_out_t
//
// one word accepted per cycle while in_stall_o is low
// the back end holds the 32-step square root and 16-step divider pipelines
// reset clears the queue and every stage valid bit
// out_stall_i, while out_valid_o is high, freezes the whole back pipeline and its output register
// in_stall_o rises only when the two-word input queue is full
module quaternion_arithmetic_unit import qau_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  qau_in_t  in_word_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output qau_out_t out_word_o
);

  logic en;
  logic fe_valid, ar_valid, sq_valid;
  fe_t  fe_word;
  bk_t  ar_word;
  sq_t  sq_word;

  assign en = !(out_valid_o && out_stall_i);

  qau_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .deq_i      (en),
    .fe_valid_o (fe_valid),
    .fe_word_o  (fe_word)
  );

  qau_arith u_arith (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fe_valid),
    .word_i  (fe_word),
    .valid_o (ar_valid),
    .word_o  (ar_word)
  );

  qau_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ar_valid),
    .word_i  (ar_word),
    .valid_o (sq_valid),
    .word_o  (sq_word)
  );

  qau_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .word_i  (sq_word),
    .valid_o (out_valid_o),
    .word_o  (out_word_o)
  );

endmodule

### src/qau_checker.sv
module qau_checker import qau_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input qau_in_t  in_word_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input qau_out_t out_word_o
);

`include "quaternion_arithmetic_unit_assert.svh"

  logic quat_zero;
  logic at_limit;

  function automatic logic is_limit(input q_t v);
    return (v == 16'sh7fff) || (v == 16'sh8000);
  endfunction

  assign quat_zero = (out_word_o.r_i == 16'sh0000) && (out_word_o.r_j == 16'sh0000) &&
                     (out_word_o.r_k == 16'sh0000) && (out_word_o.r_w == 16'sh0000);
  assign at_limit  = is_limit(out_word_o.r_i) || is_limit(out_word_o.r_j) ||
                     is_limit(out_word_o.r_k) || is_limit(out_word_o.r_w) ||
                     is_limit(out_word_o.r_scalar);

  `QAU_ASSERT_NEXT(a_in_hold, in_valid_i && in_stall_o, in_valid_i && $stable(in_word_i))
  `QAU_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_word_o))
  `QAU_ASSERT_NOW(a_zero_clean, out_valid_o && out_word_o.zero_flag, quat_zero && !out_word_o.overflow)
  `QAU_ASSERT_NOW(a_dot_alone, out_valid_o && out_word_o.r_scalar != 16'sh0000, quat_zero && !out_word_o.zero_flag)
  `QAU_ASSERT_NOW(a_ovf_limit, out_valid_o && out_word_o.overflow, at_limit)

endmodule

bind quaternion_arithmetic_unit qau_checker u_checker (.*);

### tb/tb_quaternion_arithmetic_unit.sv
`timescale 1ns / 100ps

module tb_quaternion_arithmetic_unit;
  import qau_pkg::*;

  localparam int unsigned Latency = 55;
  localparam int unsigned WatchdogLimit = 20000;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  qau_in_t  in_word_i;
  logic     out_valid_o;
  logic     out_stall_i;
  qau_out_t out_word_o;

  qau_out_t expected_words[$];
  int       n_errors;
  int       idle_pct;
  int       quiet_cycles;

  quaternion_arithmetic_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // round to nearest, ties away from zero
  function automatic longint round_shift(longint v, int k);
    longint m;
    m = ((v < 0 ? -v : v) + (64'sd1 <<< (k - 1))) >>> k;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint round_div(longint num, longint den);
    longint m;
    m = ((num < 0 ? -num : num) + den / 2) / den;
    return num < 0 ? -m : m;
  endfunction

  function automatic longint int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic logic unit_length(input longint n[4], output longint r[4]);
    longint unsigned m2;
    longint s;
    m2 = 0;
    for (int i = 0; i < 4; i++) m2 += n[i] * n[i];
    if (m2 == 0) begin
      for (int i = 0; i < 4; i++) r[i] = 0;
      return 1'b1;
    end
    s = int_sqrt(m2 << 20);
    for (int i = 0; i < 4; i++) r[i] = round_div(n[i] * (64'sd1 <<< 22), s);
    return 1'b0;
  endfunction

  function automatic q_t clamp16(longint v, inout logic ovf);
    if (v > 32767) begin
      ovf = 1'b1;
      return 16'sh7fff;
    end
    if (v < -32768) begin
      ovf = 1'b1;
      return 16'sh8000;
    end
    return q_t'(v);
  endfunction

  function automatic qau_out_t quat_result(qau_in_t w);
    longint a[4], b[4], r[4], n[4];
    longint f, scal, qv, wq, cx, cy, cz, omt;
    longint unsigned m2;
    logic zf, ovf;
    qau_out_t o;
    a = '{w.a_i, w.a_j, w.a_k, w.a_w};
    b = '{w.b_i, w.b_j, w.b_k, w.b_w};
    f = w.factor;
    r = '{0, 0, 0, 0};
    scal = 0;
    zf = 1'b0;
    ovf = 1'b0;
    case (w.mode)
      OP_ADD: for (int i = 0; i < 4; i++) r[i] = a[i] + b[i];
      OP_SUB: for (int i = 0; i < 4; i++) r[i] = a[i] - b[i];
      OP_MULT: begin
        r[0] = round_shift(a[3]*b[0] + a[0]*b[3] + a[1]*b[2] - a[2]*b[1], 12);
        r[1] = round_shift(a[3]*b[1] - a[0]*b[2] + a[1]*b[3] + a[2]*b[0], 12);
        r[2] = round_shift(a[3]*b[2] + a[0]*b[1] - a[1]*b[0] + a[2]*b[3], 12);
        r[3] = round_shift(a[3]*b[3] - a[0]*b[0] - a[1]*b[1] - a[2]*b[2], 12);
      end
      OP_CONJ: r = '{-a[0], -a[1], -a[2], a[3]};
      OP_SCALE: for (int i = 0; i < 4; i++) r[i] = round_shift(a[i] * f, 12);
      OP_DOT: scal = round_shift(a[0]*b[0] + a[1]*b[1] + a[2]*b[2] + a[3]*b[3], 12);
      OP_NORM: zf = unit_length(a, r);
      OP_INV: begin
        m2 = 0;
        for (int i = 0; i < 4; i++) m2 += a[i] * a[i];
        if (m2 == 0) begin
          zf = 1'b1;
        end else begin
          for (int i = 0; i < 4; i++)
            r[i] = round_div((i == 3 ? a[i] : -a[i]) * (64'sd1 <<< 24), longint'(m2));
        end
      end
      OP_ROT: begin
        qv = a[0]*b[0] + a[1]*b[1] + a[2]*b[2];
        wq = a[3]*a[3] - (a[0]*a[0] + a[1]*a[1] + a[2]*a[2]);
        cx = a[1]*b[2] - a[2]*b[1];
        cy = a[2]*b[0] - a[0]*b[2];
        cz = a[0]*b[1] - a[1]*b[0];
        r[0] = round_shift(2*qv*a[0] + wq*b[0] + 2*a[3]*cx, 24);
        r[1] = round_shift(2*qv*a[1] + wq*b[1] + 2*a[3]*cy, 24);
        r[2] = round_shift(2*qv*a[2] + wq*b[2] + 2*a[3]*cz, 24);
      end
      OP_MIX: begin
        omt = 4096 - f;
        for (int i = 0; i < 4; i++) r[i] = round_shift(a[i]*omt + b[i]*f, 12);
      end
      OP_NLERP: begin
        for (int i = 0; i < 4; i++) n[i] = round_shift(a[i]*4096 + (b[i]-a[i])*f, 12);
        zf = unit_length(n, r);
      end
      default: ;
    endcase
    o.r_i = clamp16(r[0], ovf);
    o.r_j = clamp16(r[1], ovf);
    o.r_k = clamp16(r[2], ovf);
    o.r_w = clamp16(r[3], ovf);
    o.r_scalar = clamp16(scal, ovf);
    o.zero_flag = zf;
    o.overflow = ovf;
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    n_errors++;
  endtask

  // send one word, with a random idle gap before it
  task automatic send_word(qau_in_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_words.push_back(quat_result(w));
    @(negedge clk_i);
  endtask

  function automatic q_t rand_q(int kind);
    case (kind)
      0: return q_t'($urandom);
      1: return q_t'($urandom_range(8192) - 4096);
      2: begin
        case ($urandom_range(3))
          0: return 16'sh7fff;
          1: return 16'sh8000;
          2: return 16'sh0000;
          default: return 16'sh1000;
        endcase
      end
      default: return q_t'($urandom_range(1024) - 512);
    endcase
  endfunction

  function automatic qau_in_t rand_word(logic [3:0] mode);
    qau_in_t w;
    int kind;
    kind = $urandom_range(3);
    w.mode = mode;
    w.a_i = rand_q(kind);
    w.a_j = rand_q(kind);
    w.a_k = rand_q(kind);
    w.a_w = rand_q(kind);
    w.b_i = rand_q(kind);
    w.b_j = rand_q(kind);
    w.b_k = rand_q(kind);
    w.b_w = rand_q(kind);
    w.factor = rand_q($urandom_range(3));
    if ($urandom_range(15) == 0) begin
      w.a_i = '0;
      w.a_j = '0;
      w.a_k = '0;
      w.a_w = '0;
      if ($urandom_range(1) == 1) begin
        w.b_i = '0;
        w.b_j = '0;
        w.b_k = '0;
        w.b_w = '0;
      end
    end
    return w;
  endfunction

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (expected_words.size() != 0);
  endtask

  task automatic test_directed();
    qau_in_t w;
    for (int m = 0; m < 16; m++) begin
      w = '{mode: m[3:0], a_i: 16'sh7fff, a_j: 16'sh8000, a_k: 16'sh7fff,
            a_w: 16'sh8000, b_i: 16'sh8000, b_j: 16'sh7fff, b_k: 16'sh8000,
            b_w: 16'sh7fff, factor: 16'sh8000};
      send_word(w);
    end
    send_word('{OP_NORM, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd5, 16'sd5, 16'sd5,
                16'sd5, 16'sd0});
    send_word('{OP_INV, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                16'sd0, 16'sd0});
    send_word('{OP_NLERP, 16'sd4096, 16'sd0, 16'sd0, 16'sd0, -16'sd4096, 16'sd0,
                16'sd0, 16'sd0, 16'sd2048});
    send_word('{OP_CONJ, 16'sh8000, 16'sd1, -16'sd1, 16'sd7, 16'sd0, 16'sd0,
                16'sd0, 16'sd0, 16'sd0});
    send_word('{OP_ROT, 16'sd0, 16'sd0, 16'sd2896, 16'sd2896, 16'sd4096, 16'sd0,
                16'sd0, 16'sd0, 16'sd0});
    send_word('{OP_NORM, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                16'sd0, 16'sd0});
    send_word('{OP_INV, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                16'sd0, 16'sd0});
  endtask

  task automatic test_random(int count);
    for (int n = 0; n < count; n++) begin
      send_word(rand_word($urandom_range(99) < 95 ? 4'($urandom_range(10))
                                                   : 4'($urandom_range(15, 11))));
      if (n == count / 2) wait_drained();
    end
  endtask

  task automatic test_no_idle(int count);
    idle_pct = 0;
    for (int n = 0; n < count; n++) send_word(rand_word(4'($urandom_range(10))));
    idle_pct = 19;
  endtask

  // result checker with random stall on the output side
  always @(posedge clk_i) begin
    qau_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      quiet_cycles <= 0;
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", 0, 0);
      end else begin
        want = expected_words.pop_front();
        if (out_word_o.r_i != want.r_i) report_mismatch("r_i", out_word_o.r_i, want.r_i);
        if (out_word_o.r_j != want.r_j) report_mismatch("r_j", out_word_o.r_j, want.r_j);
        if (out_word_o.r_k != want.r_k) report_mismatch("r_k", out_word_o.r_k, want.r_k);
        if (out_word_o.r_w != want.r_w) report_mismatch("r_w", out_word_o.r_w, want.r_w);
        if (out_word_o.r_scalar != want.r_scalar)
          report_mismatch("r_scalar", out_word_o.r_scalar, want.r_scalar);
        if (out_word_o.zero_flag != want.zero_flag)
          report_mismatch("zero_flag", out_word_o.zero_flag, want.zero_flag);
        if (out_word_o.overflow != want.overflow)
          report_mismatch("overflow", out_word_o.overflow, want.overflow);
      end
    end else if (rst_ni && in_valid_i && !in_stall_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < idle_pct);
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (quiet_cycles > WatchdogLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    n_errors = 0;
    idle_pct = 19;
    quiet_cycles = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_word_i = '0;
    out_stall_i = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random(1000);
    test_no_idle(400);
    wait_drained();
    repeat (Latency + 10) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
